// ===== rtl/core/bgd_pkg.sv =====
`timescale 1ns / 1ps

package bgd_pkg;

    localparam int TIMER_BITS_DEFAULT = 16;
    localparam int REG_BITS           = 16;
    localparam int APB_DATA_BITS      = 32;
    localparam int APB_ADDR_BITS      = 4;
    localparam int TDATA_IN_BITS      = 8;
    localparam int TDATA_OUT_BITS     = 8;

    localparam logic [REG_BITS-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [REG_BITS-1:0] LONG_RESET     = 16'd600;
    localparam logic [REG_BITS-1:0] DOUBLE_RESET   = 16'd400;

    typedef enum logic [1:0] {
        REG_DEBOUNCE = 2'd0,
        REG_LONG     = 2'd1,
        REG_DOUBLE   = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        GS_IDLE         = 3'b001,
        GS_WAIT_RELEASE = 3'b010,
        GS_WAIT_SECOND  = 3'b100
    } gesture_state_t;

    typedef struct packed {
        logic long_press;
        logic double_click;
        logic click;
    } gesture_events_t;

endpackage

// ===== rtl/core/button_gesture_detector_unit.sv =====
`timescale 1ns / 1ps

// The result beat is registered and appears in the cycle after its input beat is accepted.
// Throughput: one beat per cycle while m_tready is high; the result register frees as it is taken,
// and the timer and gesture update for a tick is combinational.
// Reset (rst_n, asynchronous, active low): timers stopped, gesture idle,
// level released, registers at their default tick counts, no result pending.
module button_gesture_detector_unit #(
    parameter int TIMER_BITS = bgd_pkg::TIMER_BITS_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [0] button_level
    input  logic [bgd_pkg::TDATA_IN_BITS-1:0]  s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [0] click, [1] double_click, [2] long_press
    output logic [bgd_pkg::TDATA_OUT_BITS-1:0] m_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bgd_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [bgd_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [bgd_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready
);

    localparam logic [31:0] TIMER_MAX = 32'((64'd1 << TIMER_BITS) - 64'd1);
    localparam logic [TIMER_BITS-1:0] TIMER_ONE = TIMER_BITS'(1);

    function automatic logic [TIMER_BITS-1:0] load_value(
        input logic [bgd_pkg::REG_BITS-1:0] r
    );
        logic [31:0] v;
        v = 32'(r);
        if (v > TIMER_MAX)
            v = TIMER_MAX;
        if (v == 32'd0)
            v = 32'd1;
        return v[TIMER_BITS-1:0];
    endfunction

    logic [bgd_pkg::REG_BITS-1:0] debounce_ticks_reg;
    logic [bgd_pkg::REG_BITS-1:0] long_ticks_reg;
    logic [bgd_pkg::REG_BITS-1:0] double_ticks_reg;

    logic                         prev_level_reg, prev_level_next;
    logic [TIMER_BITS-1:0]        deb_cnt_reg, deb_cnt_next;
    logic [TIMER_BITS-1:0]        long_cnt_reg, long_cnt_next;
    logic [TIMER_BITS-1:0]        dbl_cnt_reg, dbl_cnt_next;
    bgd_pkg::gesture_state_t      state_reg, state_next;
    logic                         pending_reg, pending_next;
    logic                         out_valid_reg;
    bgd_pkg::gesture_events_t     events_reg, events_next;

    logic       in_fire;
    logic       cfg_write;
    logic [1:0] cfg_index;
    logic       level;
    logic       deb_exp, long_exp, dbl_exp;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[3:2];
    assign s_tready  = ~out_valid_reg | m_tready;
    assign in_fire   = s_tvalid & s_tready;
    assign level     = s_tdata[0];
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(bgd_pkg::TDATA_OUT_BITS-3){1'b0}}, events_reg};

    always_comb
    begin
        case (cfg_index)
            bgd_pkg::REG_DEBOUNCE: prdata = 32'(debounce_ticks_reg);
            bgd_pkg::REG_LONG:     prdata = 32'(long_ticks_reg);
            bgd_pkg::REG_DOUBLE:   prdata = 32'(double_ticks_reg);
            default:               prdata = '0;
        endcase
    end

    always_comb
    begin
        deb_exp       = (deb_cnt_reg == TIMER_ONE);
        long_exp      = (long_cnt_reg == TIMER_ONE);
        dbl_exp       = (dbl_cnt_reg == TIMER_ONE);
        deb_cnt_next  = (deb_cnt_reg != '0) ? deb_cnt_reg - TIMER_ONE : '0;
        long_cnt_next = (long_cnt_reg != '0) ? long_cnt_reg - TIMER_ONE : '0;
        dbl_cnt_next  = (dbl_cnt_reg != '0) ? dbl_cnt_reg - TIMER_ONE : '0;
        state_next    = state_reg;
        pending_next  = pending_reg;
        events_next   = '0;

        if (deb_exp)
        begin
            if (!level)
            begin
                long_cnt_next = load_value(long_ticks_reg);
                long_exp      = 1'b0;
                state_next    = bgd_pkg::GS_WAIT_RELEASE;
            end
            else if (state_reg == bgd_pkg::GS_WAIT_RELEASE)
            begin
                long_cnt_next = '0;
                long_exp      = 1'b0;
                dbl_exp       = 1'b0;
                if (pending_reg)
                begin
                    pending_next             = 1'b0;
                    dbl_cnt_next             = '0;
                    events_next.double_click = 1'b1;
                    state_next               = bgd_pkg::GS_IDLE;
                end
                else
                begin
                    pending_next = 1'b1;
                    dbl_cnt_next = load_value(double_ticks_reg);
                    state_next   = bgd_pkg::GS_WAIT_SECOND;
                end
            end
        end

        if (long_exp && state_next == bgd_pkg::GS_WAIT_RELEASE && !level)
        begin
            events_next.long_press = 1'b1;
            state_next             = bgd_pkg::GS_IDLE;
        end

        if (dbl_exp && pending_next)
        begin
            pending_next      = 1'b0;
            events_next.click = 1'b1;
            state_next        = bgd_pkg::GS_IDLE;
        end

        // deb_cnt_next is zero exactly when the countdown is idle after this tick
        if (level != prev_level_reg && deb_cnt_next == '0)
            deb_cnt_next = load_value(debounce_ticks_reg);
        prev_level_next = level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ticks_reg <= bgd_pkg::DEBOUNCE_RESET;
            long_ticks_reg     <= bgd_pkg::LONG_RESET;
            double_ticks_reg   <= bgd_pkg::DOUBLE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                bgd_pkg::REG_DEBOUNCE: debounce_ticks_reg <= pwdata[bgd_pkg::REG_BITS-1:0];
                bgd_pkg::REG_LONG:     long_ticks_reg     <= pwdata[bgd_pkg::REG_BITS-1:0];
                bgd_pkg::REG_DOUBLE:   double_ticks_reg   <= pwdata[bgd_pkg::REG_BITS-1:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_level_reg <= 1'b1;
            deb_cnt_reg    <= '0;
            long_cnt_reg   <= '0;
            dbl_cnt_reg    <= '0;
            state_reg      <= bgd_pkg::GS_IDLE;
            pending_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                prev_level_reg <= prev_level_next;
                deb_cnt_reg    <= deb_cnt_next;
                long_cnt_reg   <= long_cnt_next;
                dbl_cnt_reg    <= dbl_cnt_next;
                state_reg      <= state_next;
                pending_reg    <= pending_next;
                out_valid_reg  <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
            events_reg <= events_next;
    end

endmodule

// ===== tb/gesture_checker.sv =====
`timescale 1ns / 1ps

module gesture_checker
    import bgd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    // [0] button_level
    input  logic [TDATA_IN_BITS-1:0]  s_tdata,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    // [0] click, [1] double_click, [2] long_press
    input  logic [TDATA_OUT_BITS-1:0] m_tdata,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [APB_ADDR_BITS-1:0]  paddr,
    input  logic [APB_DATA_BITS-1:0]  pwdata,
    input  logic [APB_DATA_BITS-1:0]  prdata,
    input  logic                      pready,
    output int                        outstanding,
    output int                        fail_count
);

    logic [REG_BITS-1:0] cfg_debounce;
    logic [REG_BITS-1:0] cfg_long;
    logic [REG_BITS-1:0] cfg_double;

    logic [REG_BITS-1:0] debounce_left;
    logic [REG_BITS-1:0] long_left;
    logic [REG_BITS-1:0] double_left;
    gesture_state_t      gesture;
    logic                level_seen;
    logic                click_pending;

    gesture_events_t     expected_events[$];
    gesture_events_t     want;
    gesture_events_t     predicted;
    logic [REG_BITS-1:0] reg_value;
    int                  beat_count;
    int                  mismatches;

    initial
    begin
        beat_count = 0;
        mismatches = 0;
        outstanding = 0;
        fail_count = 0;
    end

    function automatic logic [REG_BITS-1:0] load_ticks(input logic [REG_BITS-1:0] r);
        return (r == '0) ? REG_BITS'(1) : r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_val,
                                   input logic [31:0] got_val);
        $display("%0t: beat %0d %s: expected %0h got %0h", $time, beat_count, what,
                 exp_val, got_val);
        mismatches++;
    endtask

    task automatic predict_tick(input logic lvl, output gesture_events_t ev);
        logic debounce_fire;
        logic long_fire;
        logic double_fire;
        ev = '0;
        debounce_fire = (debounce_left == REG_BITS'(1));
        long_fire = (long_left == REG_BITS'(1));
        double_fire = (double_left == REG_BITS'(1));
        if (debounce_left != '0) debounce_left = debounce_left - REG_BITS'(1);
        if (long_left != '0) long_left = long_left - REG_BITS'(1);
        if (double_left != '0) double_left = double_left - REG_BITS'(1);

        if (debounce_fire)
        begin
            if (!lvl)
            begin
                long_left = load_ticks(cfg_long);
                long_fire = 1'b0;
                gesture = GS_WAIT_RELEASE;
            end
            else if (gesture == GS_WAIT_RELEASE)
            begin
                long_left = '0;
                long_fire = 1'b0;
                double_fire = 1'b0;
                if (click_pending)
                begin
                    click_pending = 1'b0;
                    double_left = '0;
                    ev.double_click = 1'b1;
                    gesture = GS_IDLE;
                end
                else
                begin
                    click_pending = 1'b1;
                    double_left = load_ticks(cfg_double);
                    gesture = GS_WAIT_SECOND;
                end
            end
        end

        if (long_fire && gesture == GS_WAIT_RELEASE && !lvl)
        begin
            ev.long_press = 1'b1;
            gesture = GS_IDLE;
        end

        if (double_fire && click_pending)
        begin
            click_pending = 1'b0;
            ev.click = 1'b1;
            gesture = GS_IDLE;
        end

        if (lvl != level_seen && debounce_left == '0)
            debounce_left = load_ticks(cfg_debounce);
        level_seen = lvl;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_debounce = DEBOUNCE_RESET;
            cfg_long = LONG_RESET;
            cfg_double = DOUBLE_RESET;
            debounce_left = '0;
            long_left = '0;
            double_left = '0;
            gesture = GS_IDLE;
            level_seen = 1'b1;
            click_pending = 1'b0;
            expected_events.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                    report_mismatch("result with no pending tick", 32'h0, 32'(m_tdata));
                else
                begin
                    want = expected_events.pop_front();
                    if (m_tdata[0] !== want.click)
                        report_mismatch("click", 32'(want.click), 32'(m_tdata[0]));
                    if (m_tdata[1] !== want.double_click)
                        report_mismatch("double_click", 32'(want.double_click),
                                        32'(m_tdata[1]));
                    if (m_tdata[2] !== want.long_press)
                        report_mismatch("long_press", 32'(want.long_press), 32'(m_tdata[2]));
                    if (m_tdata[TDATA_OUT_BITS-1:3] !== '0)
                        report_mismatch("pad bits", 32'h0, 32'(m_tdata[TDATA_OUT_BITS-1:3]));
                end
                beat_count++;
            end

            if (s_tvalid && s_tready)
            begin
                predict_tick(s_tdata[0], predicted);
                expected_events.push_back(predicted);
            end

            if (psel && penable && pready && paddr[1:0] == 2'b00)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        REG_DEBOUNCE: cfg_debounce = pwdata[REG_BITS-1:0];
                        REG_LONG:     cfg_long = pwdata[REG_BITS-1:0];
                        REG_DOUBLE:   cfg_double = pwdata[REG_BITS-1:0];
                        default:      ;
                    endcase
                end
                else if (paddr[3:2] != 2'd3)
                begin
                    case (paddr[3:2])
                        REG_DEBOUNCE: reg_value = cfg_debounce;
                        REG_LONG:     reg_value = cfg_long;
                        default:      reg_value = cfg_double;
                    endcase
                    if (prdata !== APB_DATA_BITS'(reg_value))
                        report_mismatch("prdata", 32'(reg_value), prdata);
                end
            end
        end
        outstanding <= expected_events.size();
        fail_count <= mismatches;
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import bgd_pkg::*;

    localparam logic [APB_ADDR_BITS-1:0] UNMAPPED_ADDR = 4'd12;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int LEN_CAP = 40;
    localparam logic [29:0] DIRECTED_LEVELS = 30'b0111_00111111_001100111_000000111;

    logic                      clk;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    // [0] button_level
    logic [TDATA_IN_BITS-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    // [0] click, [1] double_click, [2] long_press
    logic [TDATA_OUT_BITS-1:0] m_tdata;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [APB_ADDR_BITS-1:0]  paddr = '0;
    logic [APB_DATA_BITS-1:0]  pwdata = '0;
    logic [APB_DATA_BITS-1:0]  prdata;
    logic                      pready;

    int outstanding;
    int fail_count;
    int ticks_left = 0;
    int hold_requests = 0;
    int holds_done = 0;
    bit no_idle = 1'b0;
    int cur_debounce = 20;
    int cur_long = 600;
    int cur_double = 400;

    button_gesture_detector_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    gesture_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    function automatic int draw_gap();
        if (no_idle) return 0;
        return $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
    endfunction

    function automatic int pick_len(input int base);
        int b;
        b = (base < 1) ? 1 : base;
        if (b > LEN_CAP) return $urandom_range(1, LEN_CAP);
        case ($urandom_range(0, 2))
            0:       return $urandom_range(1, b);
            1:       return ((b > 1) ? b - 1 : 1) + $urandom_range(0, 2);
            default: return b + $urandom_range(1, 6);
        endcase
    endfunction

    task automatic send_level(input logic lvl);
        int gap;
        gap = draw_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {{(TDATA_IN_BITS-1){1'b0}}, lvl};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        ticks_left--;
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n) send_level(lvl);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic apb_transfer(input logic wr, input logic [APB_ADDR_BITS-1:0] addr,
                                input logic [APB_DATA_BITS-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= wr;
        paddr <= addr;
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
    endtask

    task automatic check_timers();
        apb_transfer(1'b0, {REG_DEBOUNCE, 2'b00}, '0);
        apb_transfer(1'b0, {REG_LONG, 2'b00}, '0);
        apb_transfer(1'b0, {REG_DOUBLE, 2'b00}, '0);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_timers(input int deb, input int lng, input int dbl);
        logic [31:0] junk;
        junk = $urandom;
        apb_transfer(1'b1, {REG_DEBOUNCE, 2'b00}, {junk[31:16], deb[15:0]});
        junk = $urandom;
        apb_transfer(1'b1, {REG_LONG, 2'b00}, {junk[31:16], lng[15:0]});
        junk = $urandom;
        apb_transfer(1'b1, {REG_DOUBLE, 2'b00}, {junk[31:16], dbl[15:0]});
        cur_debounce = deb;
        cur_long = lng;
        cur_double = dbl;
        check_timers();
    endtask

    // Mostly press/release pairs sized around the timers; the rest is chatter.
    task automatic run_gestures(input int budget);
        int deb_len;
        int n;
        ticks_left = budget;
        deb_len = (cur_debounce < 1) ? 1 : ((cur_debounce > LEN_CAP) ? LEN_CAP : cur_debounce);
        while (ticks_left > 0)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                send_run(1'b0, deb_len + pick_len(cur_long));
                send_run(1'b1, deb_len + pick_len(cur_double));
            end
            else
            begin
                n = $urandom_range(1, 2 * deb_len + 2);
                repeat (n) send_level(1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (holds_done < hold_requests)
            begin
                stall = HOLD_OFF_CYCLES;
                holds_done++;
            end
            else
                stall = draw_gap();
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    initial
    begin
        int deb;
        int lng;
        int dbl;
        int budget;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_timers();

        // glitch, click, double click, long press with a zero debounce register
        set_timers(0, 3, 4);
        for (int i = 29; i >= 0; i--)
            send_level(DIRECTED_LEVELS[i]);
        wait_idle();

        for (int p = 0; p < 10; p++)
        begin
            case (p)
                0: begin deb = 3; lng = 8; dbl = 6; end
                1: begin deb = 1; lng = 1; dbl = 1; end
                2: begin deb = 5; lng = 5; dbl = 5; end
                3: begin deb = 2; lng = 10; dbl = 4; end
                4: begin deb = 1; lng = 65535; dbl = 2; end
                7: begin deb = 65535; lng = 65535; dbl = 65535; end
                8:
                begin
                    deb = $urandom_range(1, 30);
                    lng = $urandom_range(1, 30);
                    dbl = $urandom_range(1, 30);
                end
                9: begin deb = 0; lng = 0; dbl = 0; end
                default:
                begin
                    deb = $urandom_range(1, 12);
                    lng = $urandom_range(1, 12);
                    dbl = $urandom_range(1, 12);
                end
            endcase
            if (p == 3)
                apb_transfer(1'b1, UNMAPPED_ADDR, $urandom);
            set_timers(deb, lng, dbl);
            no_idle = (p == 6);
            if (p == 0)
                hold_requests++;
            budget = (p == 7) ? 80 : 200;
            run_gestures(budget);
            wait_idle();
        end

        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/bgd_pkg.sv
rtl/core/button_gesture_detector_unit.sv
tb/gesture_checker.sv
tb/tb_top.sv
